// File: rtl/rmv_pkg.sv
// rmv_pkg: widths, defaults, microcode word and control store for the
// running mean / variance block. no dependencies.
package rmv_pkg;

  localparam int PIXEL_W  = 8;
  localparam int GAIN_W   = 16;
  localparam int BSL_W    = 3;
  localparam int MEAN_W   = 28;
  localparam int M2_W     = 62;
  localparam int VAR_W    = 38;
  localparam int BCOUNT_W = 24;
  localparam int PCOUNT_W = 34;

  localparam int DEFAULT_MAX_BLOCK_LOG = 5;
  localparam int DEFAULT_COUNT_BITS    = 24;

  localparam logic [BSL_W-1:0]  BSL_RESET  = 3'd3;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN     = 1'd1;

  // divider: remainder, quotient shift line and iteration counter
  localparam int REM_W = PCOUNT_W;
  localparam int SH_W  = 40;
  localparam int CNT_W = 5;
  localparam int PC_W  = 4;

  localparam logic [CNT_W-1:0] ITER_MEAN = 5'd14;
  localparam logic [CNT_W-1:0] ITER_CEIL = 5'd20;
  localparam logic [CNT_W-1:0] ITER_VAR  = 5'd19;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_DIFF,
    OP_LOAD_Q,
    OP_DIV,
    OP_MEAN,
    OP_LOAD_C,
    OP_M2,
    OP_LOAD_V,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_NO_ITEM,
    JMP_DIV_BUSY,
    JMP_OUT_FULL,
    JMP_ALWAYS
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic [CNT_W-1:0] iter;
  } uop_t;

  localparam logic [PC_W-1:0] PC_TAKE   = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV_Q  = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV_C  = 4'd6;
  localparam logic [PC_W-1:0] PC_DIV_V  = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT   = 4'd10;

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{op: OP_NOP, cond: JMP_ALWAYS, target: PC_TAKE, iter: '0};
    case (pc)
      4'd0:  u = '{op: OP_TAKE,   cond: JMP_NO_ITEM,  target: PC_TAKE,  iter: '0};
      4'd1:  u = '{op: OP_DIFF,   cond: JMP_NEVER,    target: PC_TAKE,  iter: '0};
      4'd2:  u = '{op: OP_LOAD_Q, cond: JMP_NEVER,    target: PC_TAKE,  iter: ITER_MEAN};
      4'd3:  u = '{op: OP_DIV,    cond: JMP_DIV_BUSY, target: PC_DIV_Q, iter: '0};
      4'd4:  u = '{op: OP_MEAN,   cond: JMP_NEVER,    target: PC_TAKE,  iter: '0};
      4'd5:  u = '{op: OP_LOAD_C, cond: JMP_NEVER,    target: PC_TAKE,  iter: ITER_CEIL};
      4'd6:  u = '{op: OP_DIV,    cond: JMP_DIV_BUSY, target: PC_DIV_C, iter: '0};
      4'd7:  u = '{op: OP_M2,     cond: JMP_NEVER,    target: PC_TAKE,  iter: '0};
      4'd8:  u = '{op: OP_LOAD_V, cond: JMP_NEVER,    target: PC_TAKE,  iter: ITER_VAR};
      4'd9:  u = '{op: OP_DIV,    cond: JMP_DIV_BUSY, target: PC_DIV_V, iter: '0};
      4'd10: u = '{op: OP_EMIT,   cond: JMP_OUT_FULL, target: PC_EMIT,  iter: '0};
      4'd11: u = '{op: OP_NOP,    cond: JMP_ALWAYS,   target: PC_TAKE,  iter: '0};
      default: u = '{op: OP_NOP,  cond: JMP_ALWAYS,   target: PC_TAKE,  iter: '0};
    endcase
    return u;
  endfunction

endpackage

// File: rtl/rmv_if.sv
// rmv_in_if and rmv_out_if: valid/ready channels for pixel items and
// statistics items. depends on rmv_pkg.
interface rmv_in_if;
  import rmv_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               clear_first;
  modport source(output valid, pixel, clear_first, input ready);
  modport sink(input valid, pixel, clear_first, output ready);
endinterface

interface rmv_out_if;
  import rmv_pkg::*;
  logic                valid;
  logic                ready;
  logic [MEAN_W-1:0]   mean;
  logic [M2_W-1:0]     sq_dev_sum;
  logic [VAR_W-1:0]    variance;
  logic [BCOUNT_W-1:0] block_count;
  logic                block_done;
  modport source(output valid, mean, sq_dev_sum, variance, block_count, block_done,
                 input ready);
  modport sink(input valid, mean, sq_dev_sum, variance, block_count, block_done,
               output ready);
endinterface

// File: rtl/running_mean_variance.sv
// running_mean_variance: Welford running mean and squared-deviation sum of
// gain-scaled pixels, with block counting. depends on rmv_pkg, rmv_if.
// a new pixel item is taken only once the last item's statistics item has been
// placed on the output; the shared 2-bit-per-cycle divider runs 14 + 20 + 19
// iterations for each item.
// reset (rst, synchronous): statistics zeroed, registers to defaults,
// sequencer at the take step, output empty.
module running_mean_variance #(
  parameter int MAX_BLOCK_LOG = rmv_pkg::DEFAULT_MAX_BLOCK_LOG,
  parameter int COUNT_BITS    = rmv_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmv_pkg::CFG_DATA_W-1:0] cfg_data,
  rmv_in_if.sink                         in_ch,
  rmv_out_if.source                      out_ch
);
  import rmv_pkg::*;

  localparam int IDX_W = 2 * MAX_BLOCK_LOG;

  logic [BSL_W-1:0]    block_size_log;
  logic [GAIN_W-1:0]   input_gain;

  logic [MEAN_W-1:0]   mean_acc;
  logic [M2_W-1:0]     sq_dev_acc;
  logic [PCOUNT_W-1:0] pixel_count;
  logic [IDX_W-1:0]    index_in_block;
  logic [COUNT_BITS-1:0] blocks_done;

  logic [PIXEL_W-1:0]  pix;
  logic                done;
  logic                neg;
  logic [MEAN_W-1:0]   mag;
  logic [55:0]         prod;
  logic [SH_W-1:0]     d2;
  logic                var_sat;

  logic [REM_W-1:0]    rem;
  logic [SH_W-1:0]     sh;
  logic [CNT_W-1:0]    iter;

  logic [PC_W-1:0]     pc;
  uop_t                uop;

  logic                take;
  logic                out_full;
  logic                emit;
  logic                jump;

  logic [PIXEL_W+GAIN_W-1:0] scaled;
  logic [MEAN_W-1:0]   x;
  logic [PCOUNT_W-1:0] pc_base;
  logic [IDX_W-1:0]    idx_base;
  logic [COUNT_BITS-1:0] blk_base;
  logic [BSL_W-1:0]    lg;
  logic [IDX_W-1:0]    idx_last;
  logic                done_now;
  logic [34:0]         numer_q;
  logic [40:0]         numer_c;
  logic [55:0]         prod_rnd;
  logic [SH_W-1:0]     term;
  logic [M2_W:0]       sq_sum;
  logic [REM_W-1:0]    rem_a;
  logic [REM_W-1:0]    rem_b;
  logic                qbit_a;
  logic                qbit_b;

  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
                                              input logic b,
                                              input logic [PCOUNT_W-1:0] n);
    logic [REM_W:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) begin
      return {t[REM_W-1:0] - n, 1'b1};
    end
    return {t[REM_W-1:0], 1'b0};
  endfunction

  assign uop      = ucode(pc);
  assign take     = (uop.op == OP_TAKE) && in_ch.valid;
  assign out_full = out_ch.valid && !out_ch.ready;
  assign emit     = (uop.op == OP_EMIT) && !out_full;
  assign in_ch.ready = (uop.op == OP_TAKE);

  always_comb begin
    case (uop.cond)
      JMP_NEVER:    jump = 1'b0;
      JMP_NO_ITEM:  jump = !in_ch.valid;
      JMP_DIV_BUSY: jump = (iter != CNT_W'(1));
      JMP_OUT_FULL: jump = out_full;
      JMP_ALWAYS:   jump = 1'b1;
      default:      jump = 1'b1;
    endcase
  end

  // block position and counters for the item being taken
  always_comb begin
    pc_base  = in_ch.clear_first ? '0 : pixel_count;
    idx_base = in_ch.clear_first ? '0 : index_in_block;
    blk_base = in_ch.clear_first ? '0 : blocks_done;
    lg = (block_size_log > BSL_W'(MAX_BLOCK_LOG)) ? BSL_W'(MAX_BLOCK_LOG) : block_size_log;
    idx_last = {IDX_W{1'b1}} >> (IDX_W - 2 * int'(lg));
    done_now = (idx_base >= idx_last);
  end

  assign scaled   = (PIXEL_W+GAIN_W)'(pix) * (PIXEL_W+GAIN_W)'(input_gain);
  assign x        = {scaled, 4'b0000};
  assign numer_q  = {7'b0, mag} + {2'b0, pixel_count[PCOUNT_W-1:1]};
  assign prod_rnd = prod + 56'd32768;
  assign numer_c  = {1'b0, d2} + {7'b0, pixel_count} - 41'd1;
  assign term     = d2 - sh;
  assign sq_sum   = {1'b0, sq_dev_acc} + {23'b0, term};

  // two restoring steps per cycle
  assign {rem_a, qbit_a} = div_step(rem, sh[SH_W-1], pixel_count);
  assign {rem_b, qbit_b} = div_step(rem_a, sh[SH_W-2], pixel_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc             <= PC_TAKE;
      block_size_log <= BSL_RESET;
      input_gain     <= GAIN_RESET;
      mean_acc       <= '0;
      sq_dev_acc     <= '0;
      pixel_count    <= '0;
      index_in_block <= '0;
      blocks_done    <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      pc <= jump ? uop.target : pc + PC_W'(1);

      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_SIZE_LOG: block_size_log <= cfg_data[BSL_W-1:0];
          CFG_INPUT_GAIN:     input_gain     <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (take) begin
        if (in_ch.clear_first) begin
          mean_acc   <= '0;
          sq_dev_acc <= '0;
        end
        pixel_count    <= (pc_base != '1) ? pc_base + PCOUNT_W'(1) : pc_base;
        index_in_block <= done_now ? '0 : idx_base + IDX_W'(1);
        blocks_done    <= (done_now && blk_base != '1) ? blk_base + COUNT_BITS'(1)
                                                       : blk_base;
      end

      if (uop.op == OP_MEAN) begin
        mean_acc <= neg ? mean_acc - sh[MEAN_W-1:0] : mean_acc + sh[MEAN_W-1:0];
      end

      if (uop.op == OP_M2) begin
        sq_dev_acc <= sq_sum[M2_W] ? '1 : sq_sum[M2_W-1:0];
      end

      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (uop.op)
      OP_TAKE: begin
        pix  <= in_ch.pixel;
        done <= done_now;
      end
      OP_DIFF: begin
        neg <= (x < mean_acc);
        mag <= (x < mean_acc) ? mean_acc - x : x - mean_acc;
      end
      OP_LOAD_Q: begin
        prod <= mag * mag;
        rem  <= REM_W'(numer_q[34:28]);
        sh   <= {numer_q[27:0], 12'b0};
        iter <= uop.iter;
      end
      OP_DIV: begin
        rem  <= rem_b;
        sh   <= {sh[SH_W-3:0], qbit_a, qbit_b};
        iter <= iter - CNT_W'(1);
      end
      OP_MEAN: begin
        d2 <= prod_rnd[55:16];
      end
      OP_LOAD_C: begin
        rem  <= REM_W'(numer_c[40]);
        sh   <= numer_c[39:0];
        iter <= uop.iter;
      end
      OP_LOAD_V: begin
        var_sat <= ({10'b0, sq_dev_acc[M2_W-1:VAR_W]} >= pixel_count);
        rem     <= REM_W'(sq_dev_acc[M2_W-1:VAR_W]);
        sh      <= {sq_dev_acc[VAR_W-1:0], 2'b00};
        iter    <= uop.iter;
      end
      OP_EMIT: begin
        if (emit) begin
          out_ch.mean        <= mean_acc;
          out_ch.sq_dev_sum  <= sq_dev_acc;
          out_ch.variance    <= var_sat ? '1 : sh[VAR_W-1:0];
          out_ch.block_count <= BCOUNT_W'(blocks_done);
          out_ch.block_done  <= done;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/rmv_checker.sv
// rmv_checker: port-level assertions for running_mean_variance, attached by
// bind. depends on rmv_pkg and the top level's ports.
module rmv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rmv_pkg::MEAN_W-1:0]   mean,
  input logic [rmv_pkg::M2_W-1:0]     sq_dev_sum,
  input logic [rmv_pkg::VAR_W-1:0]    variance,
  input logic [rmv_pkg::BCOUNT_W-1:0] block_count,
  input logic                         block_done
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous still in work");

  a_var_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({24'b0, variance} <= sq_dev_sum))
    else $error("variance above squared deviation sum");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean) && $stable(sq_dev_sum)
      && $stable(variance) && $stable(block_count) && $stable(block_done))
    else $error("stalled output item changed");

endmodule

bind running_mean_variance rmv_checker u_rmv_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .mean        (out_ch.mean),
  .sq_dev_sum  (out_ch.sq_dev_sum),
  .variance    (out_ch.variance),
  .block_count (out_ch.block_count),
  .block_done  (out_ch.block_done)
);

// File: tb/running_mean_variance_test.sv
`timescale 1ns / 1ps
// running_mean_variance_test: self-checking bench for the running mean / variance block.
// a scoreboard class predicts each statistics item from the pixel items taken.
// depends on rmv_pkg, rmv_in_if, rmv_out_if and running_mean_variance.
module running_mean_variance_test;
  import rmv_pkg::*;

  localparam int MAX_BLOCK_LOG = DEFAULT_MAX_BLOCK_LOG;
  localparam int COUNT_BITS    = DEFAULT_COUNT_BITS;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 80;

  localparam bit [63:0] MEAN_MASK  = (64'd1 << MEAN_W) - 64'd1;
  localparam bit [63:0] M2_MAX     = (64'd1 << M2_W) - 64'd1;
  localparam bit [63:0] VAR_MAX    = (64'd1 << VAR_W) - 64'd1;
  localparam bit [63:0] PCOUNT_MAX = (64'd1 << PCOUNT_W) - 64'd1;
  localparam bit [63:0] BLK_MAX    = (64'd1 << COUNT_BITS) - 64'd1;

  typedef struct {
    logic [MEAN_W-1:0]   mean;
    logic [M2_W-1:0]     sq_dev_sum;
    logic [VAR_W-1:0]    variance;
    logic [BCOUNT_W-1:0] block_count;
    logic                block_done;
  } stats_t;

  class stats_scoreboard;
    bit [BSL_W-1:0]  block_log;
    bit [GAIN_W-1:0] gain;
    bit [63:0]       mean_acc;
    bit [63:0]       sq_dev_acc;
    bit [63:0]       pixel_count;
    bit [63:0]       block_index;
    bit [63:0]       blocks_done;
    stats_t          expected_stats[$];
    int              errors;
    int              results_checked;
    int              blocks_closed;
    int              clears;

    function new();
      block_log = BSL_RESET;
      gain = GAIN_RESET;
      clear_stats();
    endfunction

    function void clear_stats();
      mean_acc = 0;
      sq_dev_acc = 0;
      pixel_count = 0;
      block_index = 0;
      blocks_done = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BLOCK_SIZE_LOG) begin
        block_log = data[BSL_W-1:0];
      end else if (idx == CFG_INPUT_GAIN) begin
        gain = data[GAIN_W-1:0];
      end
    endfunction

    // welford update of mean and squared-deviation sum, plus block position
    function void take_pixel(logic [PIXEL_W-1:0] pix, logic clr);
      bit [63:0] x;
      bit [63:0] n;
      bit [63:0] mag;
      bit [63:0] step;
      bit [63:0] d2;
      bit [63:0] term;
      bit [63:0] var_q;
      bit [63:0] last;
      bit        below;
      bit        closes;
      int        lg;
      stats_t    want;
      if (clr) begin
        clear_stats();
        clears++;
      end
      x = 64'(pix) * 64'(gain) * 64'd16;
      if (pixel_count < PCOUNT_MAX) begin
        pixel_count++;
      end
      n = pixel_count;
      below = x < mean_acc;
      mag = below ? mean_acc - x : x - mean_acc;
      step = (mag + (n >> 1)) / n;
      mean_acc = (below ? mean_acc - step : mean_acc + step) & MEAN_MASK;
      d2 = (mag * mag + 64'd32768) >> 16;
      term = d2 - (d2 + n - 64'd1) / n;
      if (term > M2_MAX - sq_dev_acc) begin
        sq_dev_acc = M2_MAX;
      end else begin
        sq_dev_acc = sq_dev_acc + term;
      end
      lg = (int'(block_log) > MAX_BLOCK_LOG) ? MAX_BLOCK_LOG : int'(block_log);
      last = (64'd1 << (2 * lg)) - 64'd1;
      closes = block_index >= last;
      if (closes) begin
        block_index = 0;
        blocks_closed++;
        if (blocks_done < BLK_MAX) begin
          blocks_done++;
        end
      end else begin
        block_index++;
      end
      var_q = 0;
      if (pixel_count != 0) begin
        var_q = sq_dev_acc / pixel_count;
        if (var_q > VAR_MAX) begin
          var_q = VAR_MAX;
        end
      end
      want.mean = mean_acc[MEAN_W-1:0];
      want.sq_dev_sum = sq_dev_acc[M2_W-1:0];
      want.variance = var_q[VAR_W-1:0];
      want.block_count = blocks_done[BCOUNT_W-1:0];
      want.block_done = closes;
      expected_stats.push_back(want);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_stats(stats_t got);
      stats_t want;
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t: item with none expected, expected none, actual mean %0d count %0d",
                 $time, got.mean, got.block_count);
        return;
      end
      want = expected_stats.pop_front();
      results_checked++;
      check_field("mean", want.mean, got.mean);
      check_field("sq_dev_sum", want.sq_dev_sum, got.sq_dev_sum);
      check_field("variance", want.variance, got.variance);
      check_field("block_count", want.block_count, got.block_count);
      check_field("block_done", want.block_done, got.block_done);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit idling_on = 1'b1;
  int settings_used;
  int stuck;

  stats_scoreboard sb = new();

  rmv_in_if  in_ch();
  rmv_out_if out_ch();

  running_mean_variance #(
    .MAX_BLOCK_LOG(MAX_BLOCK_LOG),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 11) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    stats_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.mean = out_ch.mean;
      got.sq_dev_sum = out_ch.sq_dev_sum;
      got.variance = out_ch.variance;
      got.block_count = out_ch.block_count;
      got.block_done = out_ch.block_done;
      sb.check_stats(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic clr);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.pixel = pix;
    in_ch.clear_first = clr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_pixel(pix, clr);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (sb.expected_stats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_register(idx, data);
  endtask

  // unused upper bits of the block size write carry random junk
  task automatic apply_settings(input logic [BSL_W-1:0] bsl, input logic [GAIN_W-1:0] gain);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    wait_idle();
    write_reg(CFG_BLOCK_SIZE_LOG, {junk[CFG_DATA_W-1:BSL_W], bsl});
    write_reg(CFG_INPUT_GAIN, gain);
    settings_used++;
  endtask

  initial begin
    logic [BSL_W-1:0]   bsl;
    logic [GAIN_W-1:0]  gain;
    logic [PIXEL_W-1:0] pix;
    logic               clr;
    logic               first_clear;
    int                 len;
    int                 clear_every;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_BLOCK_SIZE_LOG;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel = '0;
    in_ch.clear_first = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: first pixel, swings, clear mid-run
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd1, 1'b0);
    // full gain, one-pixel blocks, largest spread
    apply_settings(3'd0, 16'hFFFF);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    // zero gain pulls the mean down
    apply_settings(3'd1, 16'h0000);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd17, 1'b0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd200, 1'b0);
    // oversized block size
    apply_settings(3'd6, 16'h0FFF);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd1, 1'b0);
    apply_settings(3'd2, 16'h8001);
    send_pixel(8'd170, 1'b1);
    send_pixel(8'd85, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          bsl = 3'd0; gain = 16'hFFFF; len = 80; clear_every = 16; first_clear = 1'b1;
        end
        1: begin
          bsl = 3'd5; gain = 16'd1; len = 80; clear_every = 0; first_clear = 1'b1;
        end
        // one full oversized block and a bit more
        2: begin
          bsl = 3'd7; gain = GAIN_W'($urandom); len = 1040; clear_every = 0;
          first_clear = 1'b1;
        end
        // smaller block size while past its end
        3: begin
          bsl = 3'd2; gain = GAIN_W'($urandom); len = 80; clear_every = 0; first_clear = 1'b0;
        end
        4: begin
          bsl = 3'd6; gain = 16'h0000; len = 60; clear_every = 24; first_clear = 1'b0;
        end
        default: begin
          bsl = BSL_W'($urandom_range(0, 4));
          gain = $urandom_range(0, 1) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 8191));
          len = 80;
          case ($urandom_range(0, 2))
            0: clear_every = 0;
            1: clear_every = 8;
            default: clear_every = 40;
          endcase
          first_clear = 1'($urandom_range(0, 1));
        end
      endcase
      apply_settings(bsl, gain);
      idling_on = !(ph == 4 || ph >= 8);
      for (int k = 0; k < len; k++) begin
        if (k == 0) begin
          clr = first_clear;
        end else begin
          clr = (clear_every != 0) && ($urandom_range(1, clear_every) == 1);
        end
        if ($urandom_range(0, 7) == 0) begin
          pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
          pix = PIXEL_W'($urandom);
        end
        send_pixel(pix, clr);
      end
    end

    in_ch.valid = 1'b0;
    while (sb.expected_stats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("checked %0d statistics items with %0d block ends and %0d clears",
             sb.results_checked, sb.blocks_closed, sb.clears);
    $display("over %0d register settings, %0d field errors", settings_used + 1, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rmv_pkg.sv
rtl/rmv_if.sv
rtl/running_mean_variance.sv
rtl/rmv_checker.sv
tb/running_mean_variance_test.sv
